>>> rtl/core/rgf_pkg.sv
// ----------------------------------------------------------------------------
// rgf_pkg: shared definitions for the robust GARCH residual filter
// Register indexes, fixed-point constants and the status group of the
// shared divide/square-root unit.
// ----------------------------------------------------------------------------
package rgf_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_OMEGA     = 3'd0;
    localparam logic [2:0] CFG_ALPHA     = 3'd1;
    localparam logic [2:0] CFG_BETA      = 3'd2;
    localparam logic [2:0] CFG_THRESHOLD = 3'd3;
    localparam logic [2:0] CFG_INIT_VAR  = 3'd4;

    // Register reset values.
    localparam logic [23:0] OMEGA_RESET     = 24'd0;
    localparam logic [15:0] ALPHA_RESET     = 16'd3277;
    localparam logic [15:0] BETA_RESET      = 16'd58982;
    localparam logic [15:0] THRESHOLD_RESET = 16'd2304;
    localparam logic [31:0] INIT_VAR_RESET  = 32'd16777216;

    // Damping factor 1.005018 in Q1.16.
    localparam logic [31:0] DAMP_Q16 = 32'd65865;

    // Status reported by the divide/square-root unit.
    typedef struct packed {
        logic busy;
        logic done;
    } ds_status_t;

endpackage

>>> rtl/core/rgf_mul.sv
// ----------------------------------------------------------------------------
// rgf_mul: shared registered multiplier
// One unsigned 32 x 32 product per cycle, result registered.
// ----------------------------------------------------------------------------
module rgf_mul (
    input  logic        aclk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;
    logic [63:0] prod_next;

    // Product of the operands chosen by the sequencer.
    assign prod_next = op_a * op_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

>>> rtl/core/rgf_divsqrt.sv
// ----------------------------------------------------------------------------
// rgf_divsqrt: iterative divide then square root
// One compare-and-subtract unit does 64 restoring division steps and then
// 32 digit-by-digit square root steps on the quotient.
// ----------------------------------------------------------------------------
module rgf_divsqrt (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [63:0]         dividend,
    input  logic [31:0]         divisor,
    output rgf_pkg::ds_status_t status,
    output logic [31:0]         root
);

    localparam logic [5:0] DIV_LAST  = 6'd63;
    localparam logic [5:0] SQRT_LAST = 6'd31;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        sqrt_reg, sqrt_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] x_reg, x_next;
    logic [35:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [31:0] d_reg, d_next;

    logic [35:0] shifted;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;

    // Shared compare and subtract.
    always_comb begin
        if (sqrt_reg) begin
            shifted = {rem_reg[33:0], x_reg[63:62]};
            trial   = {2'b00, root_reg, 2'b01};
        end else begin
            shifted = {rem_reg[34:0], x_reg[63]};
            trial   = {4'b0000, d_reg};
        end
        ge   = (shifted >= trial);
        diff = shifted - trial;
    end

    // Step sequencing: division phase, then square root phase.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sqrt_next = sqrt_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        d_next    = d_reg;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            sqrt_next = 1'b0;
            cnt_next  = '0;
            x_next    = dividend;
            rem_next  = '0;
            root_next = '0;
            d_next    = divisor;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 6'd1;
            rem_next = ge ? diff : shifted;
            if (sqrt_reg) begin
                x_next    = {x_reg[61:0], 2'b00};
                root_next = {root_reg[30:0], ge};
                if (cnt_reg == SQRT_LAST) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end else begin
                x_next = {x_reg[62:0], ge};
                if (cnt_reg == DIV_LAST) begin
                    // Quotient complete; the root starts from a clear remainder.
                    sqrt_next = 1'b1;
                    cnt_next  = '0;
                    rem_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sqrt_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            sqrt_reg <= sqrt_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        d_reg    <= d_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign root        = root_reg;

    // A finished result never coincides with work in progress.
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divsqrt done while busy");

    // The count stays inside the square root range in that phase.
    a_sqrt_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && sqrt_reg) |-> (cnt_reg <= SQRT_LAST))
        else $error("divsqrt root count out of range");

    // A start while idle always makes the unit busy.
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (start && !busy_reg) |=> busy_reg)
        else $error("divsqrt did not start");

endmodule

>>> rtl/core/robust_garch_residual_filter.sv
// ----------------------------------------------------------------------------
// robust_garch_residual_filter: robust GARCH(1,1) variance and residual
// Updates the conditional variance from the previous sample, damping
// outliers, and reports the standardized residual of each return.
// ----------------------------------------------------------------------------
// Each sample runs the variance update on the shared multiplier, then the
// 96-step divide and square root unit; the first sample of a series, or after
// reset, starts from the initial variance and skips the update.
// The next sample is taken only once the result of the last sits in the
// output register; samples do not overlap.
// Reset (aresetn low, synchronous) restores register defaults and clears history.
module robust_garch_residual_filter (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_addr,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_series_start,
    input  logic signed [23:0] s_ret_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [23:0] m_residual,
    output logic [31:0]        m_variance,
    output logic               m_outlier_used,
    output logic               m_saturated
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PR2    = 4'd1;
    localparam logic [3:0] S_LIM    = 4'd2;
    localparam logic [3:0] S_CMP    = 4'd3;
    localparam logic [3:0] S_ALO    = 4'd4;
    localparam logic [3:0] S_AHI    = 4'd5;
    localparam logic [3:0] S_BETA   = 4'd6;
    localparam logic [3:0] S_AD     = 4'd7;
    localparam logic [3:0] S_ADPV   = 4'd8;
    localparam logic [3:0] S_ROUND  = 4'd9;
    localparam logic [3:0] S_R2     = 4'd10;
    localparam logic [3:0] S_DSTART = 4'd11;
    localparam logic [3:0] S_WAIT   = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13;

    localparam logic [23:0] CAP_POS = 24'h7FFFFF;
    localparam logic [23:0] CAP_NEG = 24'h800000;

    // Configuration registers.
    logic [23:0] omega_reg;
    logic [15:0] alpha_reg;
    logic [15:0] beta_reg;
    logic [15:0] thr_reg;
    logic [31:0] init_var_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            omega_reg    <= rgf_pkg::OMEGA_RESET;
            alpha_reg    <= rgf_pkg::ALPHA_RESET;
            beta_reg     <= rgf_pkg::BETA_RESET;
            thr_reg      <= rgf_pkg::THRESHOLD_RESET;
            init_var_reg <= rgf_pkg::INIT_VAR_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                rgf_pkg::CFG_OMEGA:     omega_reg    <= cfg_wdata[23:0];
                rgf_pkg::CFG_ALPHA:     alpha_reg    <= cfg_wdata[15:0];
                rgf_pkg::CFG_BETA:      beta_reg     <= cfg_wdata[15:0];
                rgf_pkg::CFG_THRESHOLD: thr_reg      <= cfg_wdata[15:0];
                rgf_pkg::CFG_INIT_VAR:  init_var_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer and working registers.
    logic [3:0]  state_reg, state_next;
    logic        hist_reg, hist_next;
    logic [23:0] prev_ret_reg, prev_ret_next;
    logic [31:0] prev_var_reg, prev_var_next;
    logic        start_reg, start_next;
    logic [23:0] ret_reg, ret_next;
    logic [23:0] rmag_reg, rmag_next;
    logic        neg_reg, neg_next;
    logic [46:0] pr2_reg, pr2_next;
    logic [63:0] acc_reg, acc_next;
    logic [51:0] sum_reg, sum_next;
    logic [31:0] h_reg, h_next;
    logic        outl_reg, outl_next;
    logic        sat_reg, sat_next;
    logic [23:0] mres_reg, mres_next;

    // Output register.
    logic               m_valid_reg, m_valid_next;
    logic signed [23:0] m_residual_reg, m_residual_next;
    logic [31:0]        m_variance_reg, m_variance_next;
    logic               m_outl_reg, m_outl_next;
    logic               m_sat_reg, m_sat_next;

    // Shared units.
    logic [31:0]         op_a;
    logic [31:0]         op_b;
    logic [63:0]         prod;
    logic                ds_start;
    logic [63:0]         ds_dividend;
    rgf_pkg::ds_status_t ds_status;
    logic [31:0]         ds_root;

    rgf_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    rgf_divsqrt u_divsqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ds_start),
        .dividend (ds_dividend),
        .divisor  (h_reg),
        .status   (ds_status),
        .root     (ds_root)
    );

    logic [23:0] pmag;
    logic [23:0] in_mag;
    logic [63:0] lim;
    logic [17:0] ad;
    logic [17:0] ad_beta;
    logic [51:0] rounded;
    logic [23:0] cap;

    // Magnitudes of the previous and the incoming return.
    assign pmag   = prev_ret_reg[23] ? (~prev_ret_reg + 24'd1) : prev_ret_reg;
    assign in_mag = s_ret_sample[23] ? (~s_ret_sample + 24'sd1) : s_ret_sample;

    assign lim     = {prod[55:0], 8'd0};
    assign ad      = 18'((prod[33:0] + 34'h8000) >> 16);
    assign ad_beta = ad + {2'b00, beta_reg};
    assign rounded = sum_reg + 52'h8000;
    assign cap     = neg_reg ? CAP_NEG : CAP_POS;

    assign ds_dividend = {prod[47:0], 16'd0};
    assign s_ready     = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        hist_next       = hist_reg;
        prev_ret_next   = prev_ret_reg;
        prev_var_next   = prev_var_reg;
        start_next      = start_reg;
        ret_next        = ret_reg;
        rmag_next       = rmag_reg;
        neg_next        = neg_reg;
        pr2_next        = pr2_reg;
        acc_next        = acc_reg;
        sum_next        = sum_reg;
        h_next          = h_reg;
        outl_next       = outl_reg;
        sat_next        = sat_reg;
        mres_next       = mres_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_residual_next = m_residual_reg;
        m_variance_next = m_variance_reg;
        m_outl_next     = m_outl_reg;
        m_sat_next      = m_sat_reg;
        op_a            = '0;
        op_b            = '0;
        ds_start        = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    start_next = s_series_start;
                    ret_next   = s_ret_sample;
                    rmag_next  = in_mag;
                    neg_next   = s_ret_sample[23];
                    outl_next  = 1'b0;
                    sat_next   = 1'b0;
                    if (s_series_start || !hist_reg) begin
                        h_next     = init_var_reg;
                        state_next = S_R2;
                    end else begin
                        state_next = S_PR2;
                    end
                end
            end
            S_PR2: begin
                op_a       = {8'd0, pmag};
                op_b       = {8'd0, pmag};
                state_next = S_LIM;
            end
            S_LIM: begin
                pr2_next   = prod[46:0];
                op_a       = {16'd0, thr_reg};
                op_b       = prev_var_reg;
                state_next = S_CMP;
            end
            S_CMP: begin
                // Plain update when the squared return is under the limit.
                if ({17'd0, pr2_reg} < lim) begin
                    op_a       = {16'd0, alpha_reg};
                    op_b       = {8'd0, pr2_reg[23:0]};
                    state_next = S_ALO;
                end else begin
                    outl_next  = 1'b1;
                    op_a       = {16'd0, alpha_reg};
                    op_b       = rgf_pkg::DAMP_Q16;
                    state_next = S_AD;
                end
            end
            S_ALO: begin
                acc_next   = prod;
                op_a       = {16'd0, alpha_reg};
                op_b       = {9'd0, pr2_reg[46:24]};
                state_next = S_AHI;
            end
            S_AHI: begin
                acc_next   = acc_reg + {prod[39:0], 24'd0};
                op_a       = {16'd0, beta_reg};
                op_b       = prev_var_reg;
                state_next = S_BETA;
            end
            S_BETA: begin
                sum_next   = {12'd0, omega_reg, 16'd0} + 52'(acc_reg >> 16) + prod[51:0];
                state_next = S_ROUND;
            end
            S_AD: begin
                op_a       = {14'd0, ad_beta};
                op_b       = prev_var_reg;
                state_next = S_ADPV;
            end
            S_ADPV: begin
                sum_next   = {12'd0, omega_reg, 16'd0} + prod[51:0];
                state_next = S_ROUND;
            end
            S_ROUND: begin
                // Round half up to Q8.24 and clip.
                if (|rounded[51:48]) begin
                    h_next   = 32'hFFFFFFFF;
                    sat_next = 1'b1;
                end else begin
                    h_next = rounded[47:16];
                end
                state_next = S_R2;
            end
            S_R2: begin
                op_a       = {8'd0, rmag_reg};
                op_b       = {8'd0, rmag_reg};
                state_next = S_DSTART;
            end
            S_DSTART: begin
                if (rmag_reg == 24'd0) begin
                    mres_next  = '0;
                    state_next = S_DONE;
                end else if (h_reg == 32'd0) begin
                    mres_next  = cap;
                    sat_next   = 1'b1;
                    state_next = S_DONE;
                end else begin
                    ds_start   = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                if (ds_status.done) begin
                    if (ds_root > {8'd0, cap}) begin
                        mres_next = cap;
                        sat_next  = 1'b1;
                    end else begin
                        mres_next = ds_root[23:0];
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // Move the result into the output register once it is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_residual_next = neg_reg ? (~mres_reg + 24'd1) : mres_reg;
                    m_variance_next = h_reg;
                    m_outl_next     = outl_reg;
                    m_sat_next      = sat_reg;
                    prev_ret_next   = ret_reg;
                    prev_var_next   = h_reg;
                    hist_next       = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            hist_reg     <= 1'b0;
            prev_ret_reg <= '0;
            prev_var_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            hist_reg     <= hist_next;
            prev_ret_reg <= prev_ret_next;
            prev_var_reg <= prev_var_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        start_reg      <= start_next;
        ret_reg        <= ret_next;
        rmag_reg       <= rmag_next;
        neg_reg        <= neg_next;
        pr2_reg        <= pr2_next;
        acc_reg        <= acc_next;
        sum_reg        <= sum_next;
        h_reg          <= h_next;
        outl_reg       <= outl_next;
        sat_reg        <= sat_next;
        mres_reg       <= mres_next;
        m_residual_reg <= m_residual_next;
        m_variance_reg <= m_variance_next;
        m_outl_reg     <= m_outl_next;
        m_sat_reg      <= m_sat_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_residual     = m_residual_reg;
    assign m_variance     = m_variance_reg;
    assign m_outlier_used = m_outl_reg;
    assign m_saturated    = m_sat_reg;

    // The input side opens only while the root unit is idle.
    a_ready_unit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !ds_status.busy)
        else $error("input ready while root unit busy");

    // The root unit reports completion only while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        ds_status.done |-> (state_reg == S_WAIT))
        else $error("root result outside wait state");

    // An input transfer always starts the sequencer.
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != S_IDLE))
        else $error("sequencer stayed idle after transfer");

    // A sample that opens a series never reports the damped update.
    a_start_no_outlier: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && start_reg) |-> !outl_reg)
        else $error("damped update on first sample");

endmodule
